@@ hdl/dtmf_pkg.sv @@
// Package: shared constants, types, keypad decode and sine table build for the DTMF generator.
`timescale 1ns / 1ps
package dtmf_pkg;

  localparam int PHASE_BITS       = 32;
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int TONE_AMPLITUDE   = 8192;
  localparam int SINE_IDX_BITS    = $clog2(SINE_TABLE_DEPTH);
  localparam int ROM_W            = $clog2(TONE_AMPLITUDE + 1) + 1;
  localparam int SAMPLE_W         = 16;
  localparam int KEY_W            = 8;
  localparam int HZ_W             = 11;
  localparam int STEP_HZ_W        = 21;
  localparam int COUNT_W          = 16;
  localparam int POS_W            = COUNT_W + 1;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = STEP_HZ_W;
  localparam int QUEUE_DEPTH      = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_PER_HZ  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TONE_SAMPLES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_SAMPLES  = 2'd2;

  localparam logic [STEP_HZ_W-1:0] RST_STEP_PER_HZ  = 21'd97392;
  localparam logic [COUNT_W-1:0]   RST_TONE_SAMPLES = 16'd7938;
  localparam logic [COUNT_W-1:0]   RST_GAP_SAMPLES  = 16'd3528;

  localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1847;
  localparam logic [63:0] ONE_Q60     = 64'h1000000000000000;

  typedef logic [SINE_TABLE_DEPTH-1:0][ROM_W-1:0] sine_rom_t;

  // word passed from the decode front to the synthesis back end
  typedef struct packed {
    logic                  load;
    logic                  key_ok;
    logic [PHASE_BITS-1:0] low_step;
    logic [PHASE_BITS-1:0] high_step;
  } q_word_t;

  function automatic logic [HZ_W-1:0] row_hz(input logic [1:0] row);
    logic [HZ_W-1:0] hz;
    unique case (row)
      2'd0:    hz = 11'd697;
      2'd1:    hz = 11'd770;
      2'd2:    hz = 11'd852;
      default: hz = 11'd941;
    endcase
    return hz;
  endfunction

  function automatic logic [HZ_W-1:0] col_hz(input logic [1:0] col);
    logic [HZ_W-1:0] hz;
    unique case (col)
      2'd0:    hz = 11'd1209;
      2'd1:    hz = 11'd1336;
      2'd2:    hz = 11'd1477;
      default: hz = 11'd1633;
    endcase
    return hz;
  endfunction

  // (a*b) >> 60, truncated
  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  function automatic logic [63:0] series_div(input logic [63:0] v, input logic odd,
                                             input logic [3:0] n);
    logic [63:0] d;
    d = v;
    if (odd) begin
      case (n)
        4'd0:    d = v / 64'd6;
        4'd1:    d = v / 64'd20;
        4'd2:    d = v / 64'd42;
        4'd3:    d = v / 64'd72;
        4'd4:    d = v / 64'd110;
        4'd5:    d = v / 64'd156;
        4'd6:    d = v / 64'd210;
        4'd7:    d = v / 64'd272;
        4'd8:    d = v / 64'd342;
        4'd9:    d = v / 64'd420;
        4'd10:   d = v / 64'd506;
        4'd11:   d = v / 64'd600;
        4'd12:   d = v / 64'd702;
        default: d = v / 64'd812;
      endcase
    end else begin
      case (n)
        4'd0:    d = v / 64'd2;
        4'd1:    d = v / 64'd12;
        4'd2:    d = v / 64'd30;
        4'd3:    d = v / 64'd56;
        4'd4:    d = v / 64'd90;
        4'd5:    d = v / 64'd132;
        4'd6:    d = v / 64'd182;
        4'd7:    d = v / 64'd240;
        4'd8:    d = v / 64'd306;
        4'd9:    d = v / 64'd380;
        4'd10:   d = v / 64'd462;
        4'd11:   d = v / 64'd552;
        4'd12:   d = v / 64'd650;
        default: d = v / 64'd756;
      endcase
    end
    return d;
  endfunction

  // Taylor series of sin (odd) or cos (even) on [0, pi/2), Q60
  function automatic logic [63:0] series_q60(input logic [63:0] x, input logic odd);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x2   = mul_q60(x, x);
    term = odd ? x : ONE_Q60;
    sum  = 64'd0;
    for (int n = 0; n < 14; n++) begin
      if ((n % 2) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
      term = series_div(mul_q60(term, x2), odd, n[3:0]);
    end
    return sum;
  endfunction

  function automatic sine_rom_t build_rom();
    sine_rom_t   rom;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] s;
    logic [63:0] mag;
    logic [63:0] n;
    logic        cosine;
    logic        half;
    n = 64'(SINE_TABLE_DEPTH);
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      q      = (64'd4 * 64'(k)) / SINE_TABLE_DEPTH;
      r      = 64'd4 * 64'(k) - q * n;
      x      = (HALF_PI_Q60 / SINE_TABLE_DEPTH) * r
               + ((HALF_PI_Q60 % SINE_TABLE_DEPTH) * r) / SINE_TABLE_DEPTH;
      cosine = q[0];
      s      = series_q60(x, !cosine);
      half   = cosine ? (64'd3 * r == 64'd2 * n) : (64'd3 * r == n);
      if (half) begin
        mag = (64'(TONE_AMPLITUDE) + 64'd1) >> 1;
      end else begin
        mag = (64'(TONE_AMPLITUDE) * (s >> 16) + (64'd1 << 43)) >> 44;
      end
      rom[k] = (q >= 64'd2) ? ROM_W'(64'd0 - mag) : ROM_W'(mag);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_rom();

endpackage

@@ hdl/dtmf_front.sv @@
// Front end: folds and decodes the key and works out both phase steps for a load word.
`timescale 1ns / 1ps
module dtmf_front (
  input  logic                           in_command,
  input  logic [dtmf_pkg::KEY_W-1:0]     in_key_char,
  input  logic [dtmf_pkg::STEP_HZ_W-1:0] step_per_hz,
  output dtmf_pkg::q_word_t              word_out
);
  import dtmf_pkg::*;

  logic [KEY_W-1:0] key_up;
  logic [3:0]       key_idx;
  logic             key_ok;
  logic [HZ_W+STEP_HZ_W-1:0] low_prod;
  logic [HZ_W+STEP_HZ_W-1:0] high_prod;

  always_comb begin
    key_up = in_key_char;
    if (in_key_char >= 8'h61 && in_key_char <= 8'h7A) begin
      key_up = in_key_char - 8'h20;
    end
  end

  always_comb begin
    key_ok  = 1'b1;
    key_idx = 4'd0;
    unique case (key_up)
      8'h31:   key_idx = 4'd0;   // 1
      8'h32:   key_idx = 4'd1;   // 2
      8'h33:   key_idx = 4'd2;   // 3
      8'h41:   key_idx = 4'd3;   // A
      8'h34:   key_idx = 4'd4;   // 4
      8'h35:   key_idx = 4'd5;   // 5
      8'h36:   key_idx = 4'd6;   // 6
      8'h42:   key_idx = 4'd7;   // B
      8'h37:   key_idx = 4'd8;   // 7
      8'h38:   key_idx = 4'd9;   // 8
      8'h39:   key_idx = 4'd10;  // 9
      8'h43:   key_idx = 4'd11;  // C
      8'h2A:   key_idx = 4'd12;  // *
      8'h30:   key_idx = 4'd13;  // 0
      8'h23:   key_idx = 4'd14;  // #
      8'h44:   key_idx = 4'd15;  // D
      default: key_ok  = 1'b0;
    endcase
  end

  assign low_prod  = {{STEP_HZ_W{1'b0}}, row_hz(key_idx[3:2])} *
                     {{HZ_W{1'b0}}, step_per_hz};
  assign high_prod = {{STEP_HZ_W{1'b0}}, col_hz(key_idx[1:0])} *
                     {{HZ_W{1'b0}}, step_per_hz};

  always_comb begin
    word_out.load      = in_command;
    word_out.key_ok    = key_ok;
    word_out.low_step  = low_prod[PHASE_BITS-1:0];
    word_out.high_step = high_prod[PHASE_BITS-1:0];
  end

endmodule

@@ hdl/dtmf_queue.sv @@
// Short FIFO between the decode front and the synthesis back end.
`timescale 1ns / 1ps
module dtmf_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  dtmf_pkg::q_word_t push_word,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output dtmf_pkg::q_word_t pop_word
);
  import dtmf_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  q_word_t          mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_word  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

@@ hdl/dtmf_back.sv @@
// Back end: burst state, phase accumulators, sine ROM reads and the output register.
`timescale 1ns / 1ps
module dtmf_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_valid,
  input  dtmf_pkg::q_word_t                   q_word,
  output logic                                q_pop,
  input  logic [dtmf_pkg::COUNT_W-1:0]        tone_samples,
  input  logic [dtmf_pkg::COUNT_W-1:0]        gap_samples,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [dtmf_pkg::SAMPLE_W-1:0] out_sample_value,
  output logic                                out_in_tone,
  output logic                                out_burst_busy,
  output logic                                out_burst_last,
  output logic                                out_key_invalid
);
  import dtmf_pkg::*;

  logic [PHASE_BITS-1:0] low_phase_r, low_phase_nxt;
  logic [PHASE_BITS-1:0] high_phase_r, high_phase_nxt;
  logic [PHASE_BITS-1:0] low_step_r, low_step_nxt;
  logic [PHASE_BITS-1:0] high_step_r, high_step_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic                  busy_r, busy_nxt;

  logic [POS_W-1:0]      total;
  logic [POS_W-1:0]      pos_inc;
  logic                  tone_nxt;
  logic                  last_nxt;
  logic                  invalid_nxt;
  logic                  advance;

  // stage A: flags of the word in flight, with registered ROM data
  logic                  a_valid_r;
  logic                  a_tone_r;
  logic                  a_busy_r;
  logic                  a_last_r;
  logic                  a_invalid_r;
  logic [ROM_W-1:0]      lo_sin_r;
  logic [ROM_W-1:0]      hi_sin_r;

  // output register
  logic                  o_valid_r;
  logic signed [SAMPLE_W-1:0] o_sample_r;
  logic                  o_tone_r;
  logic                  o_busy_r;
  logic                  o_last_r;
  logic                  o_invalid_r;

  assign advance = !o_valid_r || out_ready;
  assign q_pop   = advance && q_valid;
  assign total   = {1'b0, tone_samples} + {1'b0, gap_samples};
  assign pos_inc = pos_r + 1'b1;

  always_comb begin
    low_phase_nxt  = low_phase_r;
    high_phase_nxt = high_phase_r;
    low_step_nxt   = low_step_r;
    high_step_nxt  = high_step_r;
    pos_nxt        = pos_r;
    busy_nxt       = busy_r;
    tone_nxt       = 1'b0;
    last_nxt       = 1'b0;
    invalid_nxt    = 1'b0;
    if (q_word.load) begin
      if (!q_word.key_ok) begin
        invalid_nxt = 1'b1;
        busy_nxt    = 1'b0;
      end else begin
        low_step_nxt   = q_word.low_step;
        high_step_nxt  = q_word.high_step;
        low_phase_nxt  = '0;
        high_phase_nxt = '0;
        pos_nxt        = '0;
        busy_nxt       = (total != '0);
      end
    end else if (busy_r) begin
      if (pos_r < {1'b0, tone_samples}) begin
        tone_nxt       = 1'b1;
        low_phase_nxt  = low_phase_r + low_step_r;
        high_phase_nxt = high_phase_r + high_step_r;
      end
      pos_nxt = pos_inc;
      if (pos_inc >= total) begin
        last_nxt = 1'b1;
        busy_nxt = 1'b0;
        pos_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_phase_r  <= '0;
      high_phase_r <= '0;
      low_step_r   <= '0;
      high_step_r  <= '0;
      pos_r        <= '0;
      busy_r       <= 1'b0;
      a_valid_r    <= 1'b0;
      o_valid_r    <= 1'b0;
    end else if (advance) begin
      a_valid_r <= q_valid;
      o_valid_r <= a_valid_r;
      if (q_valid) begin
        low_phase_r  <= low_phase_nxt;
        high_phase_r <= high_phase_nxt;
        low_step_r   <= low_step_nxt;
        high_step_r  <= high_step_nxt;
        pos_r        <= pos_nxt;
        busy_r       <= busy_nxt;
      end
    end
  end

  // ROM read with the phases in force before the update
  always_ff @(posedge clk) begin
    if (advance) begin
      a_tone_r    <= tone_nxt;
      a_busy_r    <= busy_nxt;
      a_last_r    <= last_nxt;
      a_invalid_r <= invalid_nxt;
      lo_sin_r    <= SINE_ROM[low_phase_r[PHASE_BITS-1 -: SINE_IDX_BITS]];
      hi_sin_r    <= SINE_ROM[high_phase_r[PHASE_BITS-1 -: SINE_IDX_BITS]];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      o_sample_r  <= a_tone_r
                     ? $signed(SAMPLE_W'($signed(lo_sin_r))) +
                       $signed(SAMPLE_W'($signed(hi_sin_r)))
                     : '0;
      o_tone_r    <= a_tone_r;
      o_busy_r    <= a_busy_r;
      o_last_r    <= a_last_r;
      o_invalid_r <= a_invalid_r;
    end
  end

  assign out_valid        = o_valid_r;
  assign out_sample_value = o_sample_r;
  assign out_in_tone      = o_tone_r;
  assign out_burst_busy   = o_busy_r;
  assign out_burst_last   = o_last_r;
  assign out_key_invalid  = o_invalid_r;

endmodule

@@ hdl/dtmf_tone_generator.sv @@
// Top level of the DTMF keypad tone generator: configuration registers and block wiring.
`timescale 1ns / 1ps
// Takes one word per clock while in_ready is high and gives one result word per input word,
// in order. A load word (in_command = 1) with a valid key picks the key's row and column tones
// and restarts the burst; one with an unknown key flags out_key_invalid and ends the burst. A
// tick word gives the next sample: tone_samples samples of the summed sines, then gap_samples
// of zero. An accepted word passes through the input queue, the sine ROM stage, whose read
// data is registered, and then the output register. Throughput stays at one word per clock
// while out_ready is high; the two-entry input queue absorbs short output stalls.
// Configuration is to be written only while idle; the block itself does not enforce it.
module dtmf_tone_generator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_command,
  input  logic [dtmf_pkg::KEY_W-1:0]      in_key_char,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [dtmf_pkg::SAMPLE_W-1:0] out_sample_value,
  output logic                            out_in_tone,
  output logic                            out_burst_busy,
  output logic                            out_burst_last,
  output logic                            out_key_invalid,
  input  logic                            cfg_we,
  input  logic [dtmf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dtmf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dtmf_pkg::*;

  logic [STEP_HZ_W-1:0] step_per_hz_r;
  logic [COUNT_W-1:0]   tone_samples_r;
  logic [COUNT_W-1:0]   gap_samples_r;

  q_word_t front_word;
  q_word_t q_word;
  logic    q_full;
  logic    q_valid;
  logic    q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_per_hz_r  <= RST_STEP_PER_HZ;
      tone_samples_r <= RST_TONE_SAMPLES;
      gap_samples_r  <= RST_GAP_SAMPLES;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STEP_PER_HZ:  step_per_hz_r  <= cfg_data[STEP_HZ_W-1:0];
        CFG_TONE_SAMPLES: tone_samples_r <= cfg_data[COUNT_W-1:0];
        CFG_GAP_SAMPLES:  gap_samples_r  <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = !q_full;

  dtmf_front u_front (
    .in_command  (in_command),
    .in_key_char (in_key_char),
    .step_per_hz (step_per_hz_r),
    .word_out    (front_word)
  );

  dtmf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_word (front_word),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_word  (q_word)
  );

  dtmf_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_word           (q_word),
    .q_pop            (q_pop),
    .tone_samples     (tone_samples_r),
    .gap_samples      (gap_samples_r),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sample_value (out_sample_value),
    .out_in_tone      (out_in_tone),
    .out_burst_busy   (out_burst_busy),
    .out_burst_last   (out_burst_last),
    .out_key_invalid  (out_key_invalid)
  );

endmodule

@@ sim/dtmf_checker.sv @@
// Checker for the DTMF tone generator: tracks the registers, predicts each result word and compares.
`timescale 1ns / 1ps
module dtmf_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic                                 in_command,
  input  logic [dtmf_pkg::KEY_W-1:0]           in_key_char,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic signed [dtmf_pkg::SAMPLE_W-1:0] out_sample_value,
  input  logic                                 out_in_tone,
  input  logic                                 out_burst_busy,
  input  logic                                 out_burst_last,
  input  logic                                 out_key_invalid,
  input  logic                                 cfg_we,
  input  logic [dtmf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dtmf_pkg::CFG_DATA_W-1:0]      cfg_data,
  output int                                   error_count,
  output int                                   pending
);
  import dtmf_pkg::*;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       in_tone;
    logic                       burst_busy;
    logic                       burst_last;
    logic                       key_invalid;
  } tone_word_t;

  int                     sine_table [SINE_TABLE_DEPTH];
  logic [STEP_HZ_W-1:0]   step_per_hz_q;
  logic [COUNT_W-1:0]     tone_len;
  logic [COUNT_W-1:0]     gap_len;
  logic [PHASE_BITS-1:0]  row_phase;
  logic [PHASE_BITS-1:0]  col_phase;
  logic [PHASE_BITS-1:0]  row_step;
  logic [PHASE_BITS-1:0]  col_step;
  logic [POS_W-1:0]       position;
  logic                   active;
  tone_word_t             expected_words [$];
  int                     errors;

  initial begin
    real v;
    int  mag;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      v   = TONE_AMPLITUDE * $sin(2.0 * 3.14159265358979323846 * k / SINE_TABLE_DEPTH);
      mag = $rtoi(((v < 0.0) ? -v : v) + 0.5);
      sine_table[k] = (k >= SINE_TABLE_DEPTH / 2) ? -mag : mag;
    end
  end

  // keypad position 0..15 (row-major), -1 for an unknown key; lower case folds to upper
  function automatic int key_slot(input logic [KEY_W-1:0] ch);
    logic [KEY_W-1:0] c;
    int               slot;
    c = (ch >= "a" && ch <= "z") ? ch - 8'd32 : ch;
    case (c)
      "1":     slot = 0;
      "2":     slot = 1;
      "3":     slot = 2;
      "A":     slot = 3;
      "4":     slot = 4;
      "5":     slot = 5;
      "6":     slot = 6;
      "B":     slot = 7;
      "7":     slot = 8;
      "8":     slot = 9;
      "9":     slot = 10;
      "C":     slot = 11;
      "*":     slot = 12;
      "0":     slot = 13;
      "#":     slot = 14;
      "D":     slot = 15;
      default: slot = -1;
    endcase
    return slot;
  endfunction

  function automatic logic [63:0] row_freq(input int r);
    case (r)
      0:       return 64'd697;
      1:       return 64'd770;
      2:       return 64'd852;
      default: return 64'd941;
    endcase
  endfunction

  function automatic logic [63:0] col_freq(input int c);
    case (c)
      0:       return 64'd1209;
      1:       return 64'd1336;
      2:       return 64'd1477;
      default: return 64'd1633;
    endcase
  endfunction

  function automatic tone_word_t next_tone_word(input logic cmd, input logic [KEY_W-1:0] ch);
    tone_word_t       w;
    int               slot;
    logic [63:0]      prod;
    logic [POS_W-1:0] total;
    w     = '0;
    total = POS_W'(tone_len) + POS_W'(gap_len);
    if (cmd) begin
      slot = key_slot(ch);
      if (slot < 0) begin
        w.key_invalid = 1'b1;
        active        = 1'b0;
      end else begin
        prod      = row_freq(slot / 4) * 64'(step_per_hz_q);
        row_step  = prod[PHASE_BITS-1:0];
        prod      = col_freq(slot % 4) * 64'(step_per_hz_q);
        col_step  = prod[PHASE_BITS-1:0];
        row_phase = '0;
        col_phase = '0;
        position  = '0;
        active    = (total != 0);
      end
    end else if (active) begin
      if (position < POS_W'(tone_len)) begin
        w.sample  = SAMPLE_W'(sine_table[row_phase[PHASE_BITS-1 -: SINE_IDX_BITS]]
                              + sine_table[col_phase[PHASE_BITS-1 -: SINE_IDX_BITS]]);
        w.in_tone = 1'b1;
        row_phase = row_phase + row_step;
        col_phase = col_phase + col_step;
      end
      position = position + 1'b1;
      if (position >= total) begin
        w.burst_last = 1'b1;
        active       = 1'b0;
        position     = '0;
      end
    end
    w.burst_busy = active;
    return w;
  endfunction

  always @(posedge clk) begin
    tone_word_t got;
    tone_word_t want;
    if (!rst_n) begin
      step_per_hz_q = RST_STEP_PER_HZ;
      tone_len      = RST_TONE_SAMPLES;
      gap_len       = RST_GAP_SAMPLES;
      row_phase     = '0;
      col_phase     = '0;
      row_step      = '0;
      col_step      = '0;
      position      = '0;
      active        = 1'b0;
      errors        = 0;
      expected_words.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_STEP_PER_HZ:  step_per_hz_q = cfg_data[STEP_HZ_W-1:0];
          CFG_TONE_SAMPLES: tone_len      = cfg_data[COUNT_W-1:0];
          CFG_GAP_SAMPLES:  gap_len       = cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        expected_words.push_back(next_tone_word(in_command, in_key_char));
      end
      if (out_valid && out_ready) begin
        got.sample      = out_sample_value;
        got.in_tone     = out_in_tone;
        got.burst_busy  = out_burst_busy;
        got.burst_last  = out_burst_last;
        got.key_invalid = out_key_invalid;
        if (expected_words.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: unexpected word: sample %0d tone %b busy %b last %b invalid %b",
                     $realtime, got.sample, got.in_tone, got.burst_busy, got.burst_last,
                     got.key_invalid);
          end
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: mismatch: expected sample %0d tone %b busy %b last %b invalid %b",
                       $realtime, want.sample, want.in_tone, want.burst_busy, want.burst_last,
                       want.key_invalid);
              $display("%0t:           got sample %0d tone %b busy %b last %b invalid %b",
                       $realtime, got.sample, got.in_tone, got.burst_busy, got.burst_last,
                       got.key_invalid);
            end
          end
        end
      end
    end
    error_count <= errors;
    pending     <= expected_words.size();
  end

endmodule

@@ sim/tb_top.sv @@
// Testbench top for the DTMF tone generator: clock, reset, stimulus, register writes and verdict.
`timescale 1ns / 1ps
module tb_top;
  import dtmf_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_ITEMS = 85;

  logic                       clk         = 1'b0;
  logic                       rst_n       = 1'b0;
  logic                       in_valid    = 1'b0;
  logic                       in_command  = 1'b0;
  logic [KEY_W-1:0]           in_key_char = '0;
  logic                       out_ready   = 1'b0;
  logic                       cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index   = '0;
  logic [CFG_DATA_W-1:0]      cfg_data    = '0;
  logic                       in_ready;
  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] out_sample_value;
  logic                       out_in_tone;
  logic                       out_burst_busy;
  logic                       out_burst_last;
  logic                       out_key_invalid;

  int               error_count;
  int               pending;
  int               send_idle_pct = 21;
  int               recv_idle_pct = 83;
  int               stall_cycles  = 0;
  logic [COUNT_W-1:0] cur_tone = RST_TONE_SAMPLES;
  logic [COUNT_W-1:0] cur_gap  = RST_GAP_SAMPLES;

  always #5 clk = ~clk;

  dtmf_tone_generator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_key_char      (in_key_char),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sample_value (out_sample_value),
    .out_in_tone      (out_in_tone),
    .out_burst_busy   (out_burst_busy),
    .out_burst_last   (out_burst_last),
    .out_key_invalid  (out_key_invalid),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  dtmf_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_key_char      (in_key_char),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sample_value (out_sample_value),
    .out_in_tone      (out_in_tone),
    .out_burst_busy   (out_burst_busy),
    .out_burst_last   (out_burst_last),
    .out_key_invalid  (out_key_invalid),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .error_count      (error_count),
    .pending          (pending)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // called at a rising edge; returns at the edge where the word is taken
  task automatic send_word(input logic cmd, input logic [KEY_W-1:0] ch);
    int gaps;
    gaps = 0;
    while ($urandom_range(99) < send_idle_pct) gaps++;
    if (gaps > 0) begin
      in_valid <= 1'b0;
      repeat (gaps) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_command  <= cmd;
    in_key_char <= ch;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_config(input logic [STEP_HZ_W-1:0] step, input logic [COUNT_W-1:0] tone,
                              input logic [COUNT_W-1:0] gap);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_STEP_PER_HZ;
    cfg_data  <= step;
    @(posedge clk);
    cfg_index <= CFG_TONE_SAMPLES;
    cfg_data  <= {5'($urandom), tone};
    @(posedge clk);
    cfg_index <= CFG_GAP_SAMPLES;
    cfg_data  <= {5'($urandom), gap};
    @(posedge clk);
    cfg_index <= CFG_UNMAPPED;
    cfg_data  <= CFG_DATA_W'($urandom);
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_tone = tone;
    cur_gap  = gap;
  endtask

  function automatic logic [KEY_W-1:0] keypad_char(input int slot);
    case (slot)
      0:       return "1";
      1:       return "2";
      2:       return "3";
      3:       return "A";
      4:       return "4";
      5:       return "5";
      6:       return "6";
      7:       return "B";
      8:       return "7";
      9:       return "8";
      10:      return "9";
      11:      return "C";
      12:      return "*";
      13:      return "0";
      14:      return "#";
      default: return "D";
    endcase
  endfunction

  task automatic random_config();
    logic [STEP_HZ_W-1:0] step;
    logic [COUNT_W-1:0]   tone;
    logic [COUNT_W-1:0]   gap;
    case ($urandom_range(5))
      0:       step = '0;
      1:       step = 21'd1;
      2:       step = '1;
      3:       step = RST_STEP_PER_HZ;
      default: step = STEP_HZ_W'($urandom);
    endcase
    case ($urandom_range(9))
      0:       tone = '0;
      1:       tone = '1;
      2:       tone = COUNT_W'($urandom);
      default: tone = COUNT_W'($urandom_range(30, 1));
    endcase
    case ($urandom_range(9))
      0, 3:    gap = '0;
      1:       gap = '1;
      2:       gap = COUNT_W'($urandom);
      default: gap = COUNT_W'($urandom_range(15, 1));
    endcase
    write_config(step, tone, gap);
  endtask

  task automatic random_phase();
    int               sent;
    int               ticks;
    int               pick;
    logic [POS_W-1:0] total;
    logic [KEY_W-1:0] ch;
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      pick  = $urandom_range(99);
      total = POS_W'(cur_tone) + POS_W'(cur_gap);
      if (pick < 65) begin
        ch = keypad_char($urandom_range(15));
        if (ch >= "A" && ch <= "D" && $urandom_range(1) == 1) ch = ch + 8'd32;
        send_word(1'b1, ch);
        if (total > 60) begin
          ticks = $urandom_range(60, 1);
        end else if ($urandom_range(9) == 0) begin
          ticks = $urandom_range(int'(total));
        end else begin
          ticks = int'(total) + $urandom_range(2);
        end
      end else if (pick < 80) begin
        send_word(1'b1, KEY_W'($urandom));
        ticks = $urandom_range(3);
      end else begin
        send_word(1'($urandom), KEY_W'($urandom));
        ticks = 0;
      end
      sent = sent + 1 + ticks;
      repeat (ticks) send_word(1'b0, KEY_W'($urandom));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values
    send_word(1'b0, 8'hFF);
    send_word(1'b1, "5");
    repeat (3) send_word(1'b0, 8'h00);
    send_word(1'b1, 8'h00);
    send_word(1'b0, 8'h55);
    drain();

    // largest step, short burst through its end
    write_config('1, 16'd2, 16'd1);
    send_word(1'b1, "d");
    repeat (4) send_word(1'b0, 8'hAA);
    send_word(1'b1, "a");
    send_word(1'b1, "#");
    send_word(1'b0, 8'h00);
    drain();

    // empty burst
    write_config('0, 16'd0, 16'd0);
    send_word(1'b1, "*");
    send_word(1'b0, 8'h00);
    send_word(1'b1, 8'hFF);
    drain();

    // gap only
    write_config(21'd1, 16'd0, 16'd2);
    send_word(1'b1, "0");
    repeat (3) send_word(1'b0, 8'h0F);
    send_word(1'b1, "z");
    drain();

    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct <= (mode == 0) ? 21 : (mode == 1) ? 83 : 0;
      recv_idle_pct <= (mode == 0) ? 83 : (mode == 1) ? 21 : 0;
      for (int phase = 0; phase < 5; phase++) begin
        random_config();
        random_phase();
        drain();
      end
    end

    repeat (20) @(posedge clk);
    if (error_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
